### hw/rtl/qsvb_pkg.sv
// qsvb_pkg: shared types, constants and color tables for the quad shell vertex builder
// used by qsvb_ctrl, qsvb_dp and quad_shell_vertex_builder_unit; no dependencies
package qsvb_pkg;

   localparam int COORD_W   = 24;
   localparam int DIFF_W    = 25;
   localparam int PROD_W    = 50;
   localparam int NRM_W     = 52;
   localparam int SQ_W      = 50;
   localparam int MAG_W     = 25;
   localparam int STEP_W    = 24;
   localparam int BAND_W    = 5;
   localparam int THR_W     = STEP_W + BAND_W;
   localparam int PID_W     = 16;
   localparam int REM_W     = 4;
   localparam int CNT_W     = 5;
   localparam int IN_W      = 160;
   localparam int OUT_W     = 256;
   // reciprocal remainder: shift covers a 16-bit id and a divisor up to 16
   localparam int MOD_SHIFT = PID_W + 5;
   localparam int RECIP_W   = MOD_SHIFT + 1;
   localparam int QPROD_W   = PID_W + RECIP_W;

   localparam logic [1:0] CSR_CONTOUR_MODE = 2'd0;
   localparam logic [1:0] CSR_CONTOUR_STEP = 2'd1;
   localparam logic [1:0] CSR_SWAP_BYTES   = 2'd2;

   localparam logic [3:0] PART_LAST = 4'd12;
   localparam logic [4:0] BAND_LAST = 5'd23;

   // commands from the controller to the datapath
   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic       mul_cross;
      logic [2:0] mul_idx;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       band_init;
      logic       band_step;
      logic       mod_init;
      logic       mod_step;
      logic       emit;
      logic [2:0] emit_idx;
      logic [1:0] corner;
   } cmd_type;

   typedef struct packed {
      logic band_hit;
   } status_type;

   // corner visited by each of the six vertices: 0,1,2,2,3,0
   function automatic logic [1:0] vertex_corner(input logic [2:0] k);
      logic [1:0] c;
      unique case (k)
         3'd0: c = 2'd0;
         3'd1: c = 2'd1;
         3'd2: c = 2'd2;
         3'd3: c = 2'd2;
         3'd4: c = 2'd3;
         default: c = 2'd0;
      endcase
      return c;
   endfunction

   // {red, green, blue}
   function automatic logic [23:0] part_rgb(input logic [3:0] i);
      logic [23:0] v;
      unique case (i)
         4'd0:  v = {8'd255, 8'd0,   8'd0};
         4'd1:  v = {8'd0,   8'd255, 8'd0};
         4'd2:  v = {8'd0,   8'd0,   8'd255};
         4'd3:  v = {8'd0,   8'd255, 8'd255};
         4'd4:  v = {8'd255, 8'd0,   8'd255};
         4'd5:  v = {8'd255, 8'd255, 8'd0};
         4'd6:  v = {8'd255, 8'd0,   8'd148};
         4'd7:  v = {8'd255, 8'd191, 8'd0};
         4'd8:  v = {8'd168, 8'd255, 8'd0};
         4'd9:  v = {8'd0,   8'd255, 8'd168};
         4'd10: v = {8'd0,   8'd128, 8'd255};
         4'd11: v = {8'd255, 8'd128, 8'd0};
         default: v = {8'd0, 8'd191, 8'd255};
      endcase
      return v;
   endfunction

   function automatic logic [23:0] band_rgb(input logic [4:0] i);
      logic [23:0] v;
      unique case (i)
         5'd0:  v = {8'd0,   8'd0,   8'd255};
         5'd1:  v = {8'd0,   8'd64,  8'd255};
         5'd2:  v = {8'd0,   8'd128, 8'd255};
         5'd3:  v = {8'd0,   8'd159, 8'd255};
         5'd4:  v = {8'd0,   8'd191, 8'd255};
         5'd5:  v = {8'd0,   8'd223, 8'd255};
         5'd6:  v = {8'd0,   8'd255, 8'd255};
         5'd7:  v = {8'd0,   8'd255, 8'd224};
         5'd8:  v = {8'd0,   8'd255, 8'd168};
         5'd9:  v = {8'd0,   8'd255, 8'd84};
         5'd10: v = {8'd0,   8'd255, 8'd0};
         5'd11: v = {8'd96,  8'd255, 8'd0};
         5'd12: v = {8'd191, 8'd255, 8'd0};
         5'd13: v = {8'd223, 8'd255, 8'd0};
         5'd14: v = {8'd255, 8'd255, 8'd0};
         5'd15: v = {8'd255, 8'd223, 8'd0};
         5'd16: v = {8'd255, 8'd191, 8'd0};
         5'd17: v = {8'd255, 8'd159, 8'd0};
         5'd18: v = {8'd255, 8'd128, 8'd0};
         5'd19: v = {8'd255, 8'd64,  8'd0};
         5'd20: v = {8'd255, 8'd0,   8'd0};
         5'd21: v = {8'd255, 8'd0,   8'd74};
         5'd22: v = {8'd255, 8'd0,   8'd148};
         default: v = {8'd255, 8'd0, 8'd255};
      endcase
      return v;
   endfunction

endpackage

### hw/rtl/qsvb_ctrl.sv
// qsvb_ctrl: sequencer for the quad shell vertex builder
// depends on qsvb_pkg; drives qsvb_dp through qsvb_pkg::cmd_type
module qsvb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output qsvb_pkg::cmd_type     cmd,
   input  qsvb_pkg::status_type  status
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SQ, ST_SQRT, ST_BAND, ST_CROSS, ST_MOD, ST_EMIT
   } state_type;

   state_type                    state_ff, state_in;
   logic [qsvb_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [1:0]                   corner_ff, corner_in;
   logic                         valid_ff, valid_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      corner_in = corner_ff;
      valid_in  = valid_ff && !rsp_tready;
      cmd       = '0;
      cmd.corner   = corner_ff;
      cmd.mul_idx  = cnt_ff[2:0];
      cmd.emit_idx = cnt_ff[2:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            // three squares issued, then a wait until the last one lands in sq_ff
            cmd.mul_en = (cnt_ff < 5'd3);
            cnt_in     = cnt_ff + 5'd1;
            if (cnt_ff == 5'd4) begin
               cmd.sqrt_init = 1'b1;
               cnt_in        = '0;
               state_in      = ST_SQRT;
            end
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + 5'd1;
            if (cnt_ff == 5'd24) begin
               cmd.band_init = 1'b1;
               state_in      = ST_BAND;
            end
         end
         ST_BAND: begin
            cmd.band_step = 1'b1;
            if (status.band_hit) begin
               cnt_in = '0;
               if (corner_ff == 2'd3) begin
                  corner_in    = 2'd0;
                  cmd.mod_init = 1'b1;
                  state_in     = ST_CROSS;
               end else begin
                  corner_in = corner_ff + 2'd1;
                  state_in  = ST_IDLE;
               end
            end
         end
         ST_CROSS: begin
            cmd.mul_en    = (cnt_ff < 5'd6);
            cmd.mul_cross = 1'b1;
            cnt_in        = cnt_ff + 5'd1;
            if (cnt_ff == 5'd6) begin
               cnt_in   = '0;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            // remainder from the quotient taken at the end of the band search
            cmd.mod_step = 1'b1;
            cnt_in       = '0;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (!valid_ff || rsp_tready) begin
               cmd.emit = 1'b1;
               valid_in = 1'b1;
               cnt_in   = cnt_ff + 5'd1;
               if (cnt_ff == 5'd5) begin
                  cnt_in   = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         corner_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         corner_ff <= corner_in;
         valid_ff  <= valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken twice in a row");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!valid_ff || rsp_tready))
      else $error("output beat overwritten");
   a_emit_only_fourth: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (corner_ff == 2'd0))
      else $error("emit before all corners in");
`endif

endmodule

### hw/rtl/qsvb_dp.sv
// qsvb_dp: datapath of the quad shell vertex builder (corners, multiplier,
// square root, band search, part remainder, output register); depends on qsvb_pkg
module qsvb_dp #(
   parameter int BAND_COUNT   = 24,
   parameter int PART_COLOURS = 13
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_addr,
   input  logic [qsvb_pkg::STEP_W-1:0]   csr_wdata,
   input  logic [qsvb_pkg::IN_W-1:0]     req_tdata,
   output logic [qsvb_pkg::OUT_W-1:0]    rsp_tdata,
   output logic                          rsp_tlast,
   input  qsvb_pkg::cmd_type             cmd,
   output qsvb_pkg::status_type          status
);

   localparam int DIFF_W = qsvb_pkg::DIFF_W;
   localparam logic [4:0] BAND_END = 5'(BAND_COUNT - 1);
   localparam logic [4:0] PART_MOD = 5'(PART_COLOURS);
   // rounded-up reciprocal of the part count
   localparam logic [qsvb_pkg::RECIP_W-1:0] PART_RECIP = qsvb_pkg::RECIP_W'(
      ((1 << qsvb_pkg::MOD_SHIFT) + PART_COLOURS - 1) / PART_COLOURS);

   logic                                 mode_ff, swap_ff;
   logic [qsvb_pkg::STEP_W-1:0]          step_ff;

   logic signed [qsvb_pkg::COORD_W-1:0]  corner_ff [4][3];
   logic [qsvb_pkg::BAND_W-1:0]          band_ff [4];
   logic signed [qsvb_pkg::DIFF_W-1:0]   d_ff [3];
   logic [qsvb_pkg::PID_W-1:0]           pid_ff;

   logic signed [qsvb_pkg::PROD_W-1:0]   prod_ff;
   logic                                 tag_en_ff, tag_cross_ff;
   logic [2:0]                           tag_idx_ff;
   logic [qsvb_pkg::SQ_W-1:0]            sq_ff;
   logic signed [qsvb_pkg::NRM_W-1:0]    nrm_ff [3];

   logic [qsvb_pkg::SQ_W-1:0]            v_ff, res_ff, bit_ff;
   logic [qsvb_pkg::BAND_W-1:0]          bi_ff;
   logic [qsvb_pkg::THR_W-1:0]           thr_ff;
   logic [qsvb_pkg::PID_W-1:0]           quo_ff;
   logic [qsvb_pkg::REM_W-1:0]           rem_ff;

   logic [qsvb_pkg::OUT_W-1:0]           out_ff;
   logic                                 last_ff;

   // input unpack with optional byte swap
   logic [23:0]                          raw [6];
   logic signed [qsvb_pkg::COORD_W-1:0]  fld [6];
   logic [qsvb_pkg::PID_W-1:0]           pid_w;

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         raw[k] = req_tdata[24*k +: 24];
         fld[k] = swap_ff ? {raw[k][7:0], raw[k][15:8], raw[k][23:16]} : raw[k];
      end
      pid_w = swap_ff ? {req_tdata[151:144], req_tdata[159:152]} : req_tdata[159:144];
   end

   // diagonals and shared multiplier operands
   logic signed [qsvb_pkg::DIFF_W-1:0]   d1 [3], d2 [3];
   logic signed [qsvb_pkg::DIFF_W-1:0]   mul_a, mul_b;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         d1[k] = DIFF_W'(corner_ff[2][k]) - DIFF_W'(corner_ff[0][k]);
         d2[k] = DIFF_W'(corner_ff[3][k]) - DIFF_W'(corner_ff[1][k]);
      end
      mul_a = d_ff[0];
      mul_b = d_ff[0];
      if (!cmd.mul_cross) begin
         unique case (cmd.mul_idx)
            3'd1:    begin mul_a = d_ff[1]; mul_b = d_ff[1]; end
            3'd2:    begin mul_a = d_ff[2]; mul_b = d_ff[2]; end
            default: begin mul_a = d_ff[0]; mul_b = d_ff[0]; end
         endcase
      end else begin
         unique case (cmd.mul_idx)
            3'd0:    begin mul_a = d1[1]; mul_b = d2[2]; end
            3'd1:    begin mul_a = d1[2]; mul_b = d2[1]; end
            3'd2:    begin mul_a = d1[2]; mul_b = d2[0]; end
            3'd3:    begin mul_a = d1[0]; mul_b = d2[2]; end
            3'd4:    begin mul_a = d1[0]; mul_b = d2[1]; end
            default: begin mul_a = d1[1]; mul_b = d2[0]; end
         endcase
      end
   end

   // square root step, band compare and part remainder
   logic [qsvb_pkg::SQ_W:0]              trial;
   logic [qsvb_pkg::MAG_W-1:0]           mag;
   logic [qsvb_pkg::QPROD_W-1:0]         qprod;
   logic [qsvb_pkg::PID_W-1:0]           rem_full;
   logic [3:0]                           pidx;
   logic [1:0]                           cn;
   logic [4:0]                           bsel;
   logic [23:0]                          rgb;

   assign trial = {1'b0, res_ff} + {1'b0, bit_ff};
   assign mag   = res_ff[qsvb_pkg::MAG_W-1:0];
   assign status.band_hit = (bi_ff == BAND_END) ||
                            (thr_ff > qsvb_pkg::THR_W'(mag));
   assign qprod    = qsvb_pkg::QPROD_W'(pid_ff) * qsvb_pkg::QPROD_W'(PART_RECIP);
   assign rem_full = pid_ff - quo_ff * qsvb_pkg::PID_W'(PART_MOD);
   assign pidx  = (rem_ff > qsvb_pkg::PART_LAST) ? qsvb_pkg::PART_LAST : rem_ff;

   always_comb begin
      cn   = qsvb_pkg::vertex_corner(cmd.emit_idx);
      bsel = (band_ff[cn] > qsvb_pkg::BAND_LAST) ? qsvb_pkg::BAND_LAST : band_ff[cn];
      rgb  = mode_ff ? qsvb_pkg::band_rgb(bsel) : qsvb_pkg::part_rgb(pidx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         swap_ff   <= 1'b0;
         step_ff   <= '0;
         tag_en_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               qsvb_pkg::CSR_CONTOUR_MODE: mode_ff <= csr_wdata[0];
               qsvb_pkg::CSR_CONTOUR_STEP: step_ff <= csr_wdata;
               qsvb_pkg::CSR_SWAP_BYTES:   swap_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         tag_en_ff <= cmd.mul_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int k = 0; k < 3; k++) begin
            corner_ff[cmd.corner][k] <= fld[k];
            d_ff[k] <= DIFF_W'(fld[k]) - DIFF_W'(fld[k+3]);
         end
         pid_ff <= pid_w;
      end

      prod_ff      <= mul_a * mul_b;
      tag_cross_ff <= cmd.mul_cross;
      tag_idx_ff   <= cmd.mul_idx;
      if (tag_en_ff) begin
         if (!tag_cross_ff) begin
            sq_ff <= ((tag_idx_ff == 3'd0) ? '0 : sq_ff) + $unsigned(prod_ff);
         end else if (!tag_idx_ff[0]) begin
            nrm_ff[tag_idx_ff[2:1]] <= qsvb_pkg::NRM_W'(prod_ff);
         end else begin
            nrm_ff[tag_idx_ff[2:1]] <= nrm_ff[tag_idx_ff[2:1]] - qsvb_pkg::NRM_W'(prod_ff);
         end
      end

      if (cmd.sqrt_init) begin
         v_ff   <= sq_ff;
         res_ff <= '0;
         bit_ff <= qsvb_pkg::SQ_W'(1) << 48;
      end else if (cmd.sqrt_step) begin
         if ({1'b0, v_ff} >= trial) begin
            v_ff   <= v_ff - trial[qsvb_pkg::SQ_W-1:0];
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end

      if (cmd.band_init) begin
         bi_ff  <= '0;
         thr_ff <= '0;
      end else if (cmd.band_step) begin
         if (status.band_hit) begin
            band_ff[cmd.corner] <= bi_ff;
         end
         bi_ff  <= bi_ff + 5'd1;
         thr_ff <= thr_ff + qsvb_pkg::THR_W'(step_ff);
      end

      // quotient by reciprocal multiply, then remainder
      if (cmd.mod_init) begin
         quo_ff <= qprod[qsvb_pkg::MOD_SHIFT +: qsvb_pkg::PID_W];
      end
      if (cmd.mod_step) begin
         rem_ff <= rem_full[qsvb_pkg::REM_W-1:0];
      end

      if (cmd.emit) begin
         out_ff <= {4'd0, rgb[7:0], rgb[15:8], rgb[23:16],
                    nrm_ff[2], nrm_ff[1], nrm_ff[0],
                    corner_ff[cn][2], corner_ff[cn][1], corner_ff[cn][0]};
         last_ff <= (cmd.emit_idx == 3'd5);
      end
   end

   assign rsp_tdata = out_ff;
   assign rsp_tlast = last_ff;

endmodule

### hw/rtl/quad_shell_vertex_builder_unit.sv
// quad_shell_vertex_builder_unit: top level of the quad shell vertex builder
// depends on qsvb_pkg, qsvb_ctrl and qsvb_dp
//
//   channel | direction | beat content
//   req_*   | in        | one corner node: cur xyz, ref xyz, part id
//   rsp_*   | out       | one vertex: position, normal, color; tlast on sixth
//   csr_*   | in        | register write: contour_mode, contour_step, swap_bytes
//
// each corner beat is accepted, then the squared displacement is formed on the
// shared 25x25 multiplier, followed by the bit-pair square root and the
// band search (one threshold a cycle)
// the fourth corner adds a cross product on the same multiplier,
// the part id remainder (reciprocal multiply) and six result beats
// a stalled result beat holds in the output register; the next corner is
// taken once the last beat is loaded, even while it still waits
// reset is synchronous and clears the sequencer and the contour/swap control registers
module quad_shell_vertex_builder_unit #(
   parameter int BAND_COUNT   = 24,
   parameter int PART_COLOURS = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [1:0]    csr_addr,
   input  logic [23:0]   csr_wdata,
   input  logic          req_tvalid,
   output logic          req_tready,
   // cur_x, cur_y, cur_z, ref_x, ref_y, ref_z, part_id
   input  logic [159:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // vertex_x, vertex_y, vertex_z, normal_x, normal_y, normal_z, red, green, blue, pad
   output logic [255:0]  rsp_tdata,
   output logic          rsp_tlast
);

   qsvb_pkg::cmd_type     cmd;
   qsvb_pkg::status_type  status;

   qsvb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   qsvb_dp #(
      .BAND_COUNT   (BAND_COUNT),
      .PART_COLOURS (PART_COLOURS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
